@@ sv/pba_pkg.sv @@
// ============================================================================
// pba_pkg
// Shared types and constants for the page bitmap allocator: map geometry,
// operation and status codes, and the result of one map word update.
// ============================================================================
package pba_pkg;

  // Map geometry: one bit per page, 64 pages per map word.
  localparam int MAX_PAGES = 65536;
  localparam int WORD_BITS = 64;
  localparam int MAP_WORDS = MAX_PAGES / WORD_BITS;
  localparam int WADDR_W   = $clog2(MAP_WORDS);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int PAGE_W    = WADDR_W + BIT_W;
  localparam int CNT_W     = PAGE_W + 1;

  localparam logic [CNT_W-1:0] CNT_MAX   = '1;
  localparam logic [CNT_W-1:0] PAGE_LIM  = CNT_W'(MAX_PAGES);

  // Operation codes.
  typedef logic [2:0] op_t;
  localparam op_t OP_LOCK    = 3'd0;
  localparam op_t OP_FREE    = 3'd1;
  localparam op_t OP_RESERVE = 3'd2;
  localparam op_t OP_RELEASE = 3'd3;
  localparam op_t OP_REQUEST = 3'd4;

  // Status codes.
  typedef logic [1:0] status_t;
  localparam status_t ST_DONE       = 2'd0;
  localparam status_t ST_NO_FREE    = 2'd1;
  localparam status_t ST_OVER_LIMIT = 2'd2;

  // Control states of the allocator.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_MOD,
    S_DONE
  } state_t;

  // Result of updating one map word.
  typedef struct packed {
    logic [WORD_BITS-1:0] wdata;
    logic [BIT_W:0]       delta;
    logic                 found;
    logic [BIT_W-1:0]     bit_idx;
  } word_res_t;

endpackage

@@ sv/pba_word_unit.sv @@
// ============================================================================
// pba_word_unit
// Updates one 64-bit map word for a run or a request: builds the page mask
// for the word, sets or clears the selected bits, counts the pages changed
// and finds the lowest free page for a request.
// ============================================================================
module pba_word_unit
  import pba_pkg::*;
(
  input  logic [WORD_BITS-1:0] rdata,
  input  op_t                  op,
  input  logic [BIT_W-1:0]     lo,
  input  logic [BIT_W-1:0]     hi,
  output word_res_t            res
);

  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] free_sel;
  logic [WORD_BITS-1:0] taken_sel;
  logic [WORD_BITS-1:0] lowest;
  logic [BIT_W-1:0]     low_idx;

  // Page mask for bits lo..hi, and the free and taken pages inside it.
  always_comb begin
    mask      = ({WORD_BITS{1'b1}} << lo) &
                ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - hi));
    free_sel  = mask & ~rdata;
    taken_sel = mask & rdata;
    lowest    = free_sel & (~free_sel + {{(WORD_BITS-1){1'b0}}, 1'b1});
  end

  // Encode the isolated lowest free bit.
  always_comb begin
    low_idx = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (lowest[j]) begin
        low_idx = low_idx | BIT_W'(j);
      end
    end
  end

  // New word contents and the number of pages that changed.
  always_comb begin
    res.wdata   = rdata;
    res.delta   = '0;
    res.found   = 1'b0;
    res.bit_idx = low_idx;
    case (op)
      OP_LOCK, OP_RESERVE: begin
        res.wdata = rdata | free_sel;
        res.delta = (BIT_W+1)'($countones(free_sel));
      end
      OP_FREE, OP_RELEASE: begin
        res.wdata = rdata & ~taken_sel;
        res.delta = (BIT_W+1)'($countones(taken_sel));
      end
      OP_REQUEST: begin
        res.found = |free_sel;
        res.wdata = rdata | lowest;
        res.delta = {{BIT_W{1'b0}}, res.found};
      end
      default: begin
        res.wdata = rdata;
      end
    endcase
  end

endmodule

@@ sv/page_bitmap_allocator.sv @@
// ============================================================================
// page_bitmap_allocator
// Bitmap page allocator: one occupancy bit per page in a 1024 x 64 map
// memory, with used and reserved page counters.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready) carries operation, first_page and
//   page_count. Output channel (out_valid/out_ready) returns one item per
//   input item: page_index, status and the free, used and reserved counts.
//   Configuration channel (cfg_valid/cfg_ready, cfg_data) writes total_pages;
//   always ready. Write it only while idle; the block does not enforce this.
// Timing:
//   After reset the map is cleared one word per cycle, all 1024 words, with
//   in_ready low. Each map word visited is read, then modified and written
//   back; the next item can be taken in the cycle after a result is loaded
//   into the output register. A run visits the words from its first page
//   to its last page below the limit; a request walks from word 0 to the
//   first word with a free page, at most 1024 words. Undefined operations,
//   empty runs, runs wholly at or above the limit and requests with a zero
//   limit skip the map walk and go straight to the result.
// Stalls:
//   One item is processed at a time. A finished result waits in the output
//   register while a new item may be accepted; that item completes its map
//   work but holds its result until the output register is taken.
// ============================================================================
module page_bitmap_allocator
  import pba_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // Configuration write channel.
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CNT_W-1:0]  cfg_data,
  // Input channel.
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        operation,
  input  logic [PAGE_W-1:0] first_page,
  input  logic [CNT_W-1:0]  page_count,
  // Output channel.
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PAGE_W-1:0] page_index,
  output logic [1:0]        status,
  output logic [CNT_W-1:0]  free_pages,
  output logic [CNT_W-1:0]  used_pages,
  output logic [CNT_W-1:0]  reserved_pages
);

  state_t state;
  state_t state_next;

  logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rd_data;
  logic                 mem_we;
  logic [WADDR_W-1:0]   mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;

  logic [CNT_W-1:0]   total_reg;
  logic [CNT_W-1:0]   limit;
  logic [WADDR_W-1:0] clr_addr;

  op_t                op_r;
  logic [PAGE_W-1:0]  first_r;
  logic [CNT_W-1:0]   stop_r;
  logic [CNT_W-1:0]   stop_m1;
  logic [WADDR_W-1:0] cur_w;
  logic [WADDR_W-1:0] last_w;
  status_t            status_r;
  logic [PAGE_W-1:0]  index_r;

  logic [CNT_W-1:0] used_cnt;
  logic [CNT_W-1:0] rsv_cnt;
  logic             pend_valid;
  logic [BIT_W:0]   pend_delta;

  logic             accept;
  logic             is_run;
  logic [CNT_W:0]   end_sum;
  logic [CNT_W-1:0] stop_acc;
  logic             go;
  logic             out_load;
  logic             last_word;

  logic [BIT_W-1:0] lo;
  logic [BIT_W-1:0] hi;
  word_res_t        wres;

  logic [CNT_W:0]   taken_sum;
  logic [CNT_W-1:0] free_calc;

  // Configuration register and effective page limit.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_reg <= PAGE_LIM;
    end else if (cfg_valid) begin
      total_reg <= cfg_data;
    end
  end

  assign limit = (total_reg > PAGE_LIM) ? PAGE_LIM : total_reg;

  // Decode of an incoming item.
  assign accept   = in_valid && in_ready;
  assign is_run   = (operation == OP_LOCK) || (operation == OP_FREE) ||
                    (operation == OP_RESERVE) || (operation == OP_RELEASE);
  assign end_sum  = {1'b0, (CNT_W)'(first_page)} + {1'b0, page_count};
  assign stop_acc = (end_sum > {1'b0, limit}) ? limit : end_sum[CNT_W-1:0];
  assign go       = is_run ? ((CNT_W)'(first_page) < stop_acc)
                           : ((operation == OP_REQUEST) && (limit != '0));

  // Word bounds of the walk for the current word.
  assign stop_m1   = stop_r - {{(CNT_W-1){1'b0}}, 1'b1};
  assign last_word = (cur_w == last_w);
  assign lo = (cur_w == first_r[PAGE_W-1:BIT_W]) ? first_r[BIT_W-1:0] : '0;
  assign hi = last_word ? stop_m1[BIT_W-1:0] : '1;

  pba_word_unit u_word (
    .rdata (rd_data),
    .op    (op_r),
    .lo    (lo),
    .hi    (hi),
    .res   (wres)
  );

  // Map memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= map_mem[cur_w];
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = cur_w;
    mem_wdata  = wres.wdata;
    out_load   = 1'b0;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
        if (clr_addr == WADDR_W'(MAP_WORDS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = go ? S_READ : S_DONE;
        end
      end
      S_READ: begin
        state_next = S_MOD;
      end
      S_MOD: begin
        mem_we = 1'b1;
        if (((op_r == OP_REQUEST) && wres.found) || last_word) begin
          state_next = S_DONE;
        end else begin
          state_next = S_READ;
        end
      end
      S_DONE: begin
        if (!pend_valid && (!out_valid || out_ready)) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Clearing sweep address.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == S_CLEAR) begin
      clr_addr <= clr_addr + WADDR_W'(1);
    end
  end

  // Item context and word walk.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= operation;
      index_r <= '0;
      if (operation == OP_REQUEST) begin
        first_r  <= '0;
        stop_r   <= limit;
        cur_w    <= '0;
        status_r <= ST_NO_FREE;
      end else begin
        first_r  <= first_page;
        stop_r   <= stop_acc;
        cur_w    <= first_page[PAGE_W-1:BIT_W];
        status_r <= (is_run && (page_count != '0) && (end_sum > {1'b0, limit}))
                    ? ST_OVER_LIMIT : ST_DONE;
      end
    end else if (state == S_READ) begin
      last_w <= stop_m1[PAGE_W-1:BIT_W];
    end else if (state == S_MOD) begin
      cur_w <= cur_w + WADDR_W'(1);
      if ((op_r == OP_REQUEST) && wres.found) begin
        status_r <= ST_DONE;
        index_r  <= {cur_w, wres.bit_idx};
      end
    end
  end

  // Saturating counter arithmetic.
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
                                                input logic [BIT_W:0]   d);
    logic [CNT_W:0] s;
    s = {1'b0, c} + (CNT_W+1)'(d);
    return (s > {1'b0, CNT_MAX}) ? CNT_MAX : s[CNT_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_sub(input logic [CNT_W-1:0] c,
                                                input logic [BIT_W:0]   d);
    logic [CNT_W-1:0] dw;
    dw = (CNT_W)'(d);
    return (c > dw) ? (c - dw) : '0;
  endfunction

  // Counter update, in the cycle after each word write.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= (state == S_MOD);
    end
    if (state == S_MOD) begin
      pend_delta <= wres.delta;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_cnt <= '0;
      rsv_cnt  <= '0;
    end else if (pend_valid) begin
      case (op_r)
        OP_LOCK, OP_REQUEST: begin
          used_cnt <= sat_add(used_cnt, pend_delta);
        end
        OP_RESERVE: begin
          rsv_cnt <= sat_add(rsv_cnt, pend_delta);
        end
        OP_FREE: begin
          used_cnt <= sat_sub(used_cnt, pend_delta);
        end
        OP_RELEASE: begin
          rsv_cnt <= sat_sub(rsv_cnt, pend_delta);
        end
        default: begin
          used_cnt <= used_cnt;
        end
      endcase
    end
  end

  // Free pages: limit minus used and reserved, held at zero.
  assign taken_sum = {1'b0, used_cnt} + {1'b0, rsv_cnt};
  assign free_calc = ({1'b0, limit} > taken_sum)
                     ? (limit - taken_sum[CNT_W-1:0]) : '0;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      page_index     <= index_r;
      status         <= status_r;
      free_pages     <= free_calc;
      used_pages     <= used_cnt;
      reserved_pages <= rsv_cnt;
    end
  end

endmodule
